// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the cursor FIFO.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds.
`define CFQ_ASSERT_IMPLY(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// Check that cond never holds.
`define CFQ_ASSERT_NEVER(lbl, clk_i, rst_ni, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
		else $error(msg);

`endif

// ===== design/cfq_pkg.sv =====
// Types and constants of the cursor FIFO.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package cfq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_BITS  = 32;
	localparam int FIELD_BITS = 32;
	localparam int COUNT_BITS = 5;
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_PUSH    = 3'd0,
		KIND_POP     = 3'd1,
		KIND_HEAD    = 3'd2,
		KIND_ADVANCE = 3'd3,
		KIND_REMOVE  = 3'd4
	} kind_t;

	// Update of the entry store for one operation.
	typedef struct packed {
		logic                 en;
		logic                 wr_en;
		logic [IDX_BITS-1:0]  wr_idx;
		logic [DATA_BITS-1:0] wdata;
		logic                 shift_en;
		logic [IDX_BITS-1:0]  shift_pos;
	} store_cmd_t;

	// One result, as it leaves the control logic.
	typedef struct packed {
		logic                  ok;
		logic [FIELD_BITS-1:0] taken_value;
		logic [COUNT_BITS-1:0] count;
		logic                  cursor_valid;
		logic [FIELD_BITS-1:0] cursor_value;
	} result_t;

endpackage

// ===== design/cfq_store.sv =====
// Compacting entry array of the cursor FIFO: parallel shift-down and tail write.
// Depends on cfq_pkg.
`timescale 1ns / 1ps

module cfq_store
	import cfq_pkg::*;
(
	input  logic                 clk,
	input  store_cmd_t           cmd,
	input  logic [IDX_BITS-1:0]  take_idx,
	output logic [DATA_BITS-1:0] take_data,
	input  logic [IDX_BITS-1:0]  look_idx,
	output logic [DATA_BITS-1:0] look_data
);

	logic [DATA_BITS-1:0] mem_q  [DEPTH];
	logic [DATA_BITS-1:0] mem_d  [DEPTH];

	always_comb begin
		mem_d = mem_q;
		if (cmd.shift_en) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (IDX_BITS'(i) >= cmd.shift_pos) begin
					mem_d[i] = mem_q[i + 1];
				end
			end
		end
		if (cmd.wr_en) begin
			mem_d[cmd.wr_idx] = cmd.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			mem_q <= mem_d;
		end
	end

	// Taken word comes from the state before the step, cursor word from after it.
	assign take_data = mem_q[take_idx];
	assign look_data = mem_d[look_idx];

endmodule

// ===== design/cfq_ctrl.sv =====
// Count and cursor state of the cursor FIFO, and the result of each operation.
// Depends on cfq_pkg; drives cfq_store.
`timescale 1ns / 1ps

module cfq_ctrl
	import cfq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [2:0]           kind,
	input  logic [DATA_BITS-1:0] wdata,
	output store_cmd_t           cmd,
	output logic [IDX_BITS-1:0]  take_idx,
	input  logic [DATA_BITS-1:0] take_data,
	output logic [IDX_BITS-1:0]  look_idx,
	input  logic [DATA_BITS-1:0] look_data,
	output result_t              res
);

	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic [IDX_BITS-1:0] idx_q, idx_d;
	logic                live_q, live_d;
	logic                ok;
	logic                take_use;
	logic [CNT_BITS-1:0] idx_plus;
	logic                cur_vld;

	assign idx_plus = CNT_BITS'(idx_q) + CNT_BITS'(1);

	always_comb begin
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		live_d       = live_q;
		ok           = 1'b0;
		take_use     = 1'b0;
		take_idx     = '0;
		cmd          = '0;
		cmd.en       = en;
		cmd.wdata    = wdata;
		unique case (kind)
			KIND_PUSH: begin
				if (cnt_q != CNT_BITS'(DEPTH)) begin
					ok         = 1'b1;
					cmd.wr_en  = 1'b1;
					cmd.wr_idx = IDX_BITS'(cnt_q);
					cnt_d      = cnt_q + CNT_BITS'(1);
				end
			end
			KIND_POP: begin
				if (cnt_q != '0) begin
					ok            = 1'b1;
					take_use      = 1'b1;
					cmd.shift_en  = 1'b1;
					cnt_d         = cnt_q - CNT_BITS'(1);
					if (live_q && idx_q != '0) begin
						idx_d = idx_q - IDX_BITS'(1);
					end
					if (cnt_q == CNT_BITS'(1)) begin
						live_d = 1'b0;
						idx_d  = '0;
					end
				end
			end
			KIND_HEAD: begin
				if (cnt_q != '0) begin
					ok     = 1'b1;
					idx_d  = '0;
					live_d = 1'b1;
				end
			end
			KIND_ADVANCE: begin
				if (live_q && cnt_q != '0) begin
					ok = 1'b1;
					if (idx_plus >= cnt_q) begin
						live_d = 1'b0;
						idx_d  = '0;
					end else begin
						idx_d = idx_q + IDX_BITS'(1);
					end
				end
			end
			KIND_REMOVE: begin
				if (live_q && CNT_BITS'(idx_q) < cnt_q) begin
					ok            = 1'b1;
					take_use      = 1'b1;
					take_idx      = idx_q;
					cmd.shift_en  = 1'b1;
					cmd.shift_pos = idx_q;
					cnt_d         = cnt_q - CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(1)) begin
						live_d = 1'b0;
						idx_d  = '0;
					end else if (idx_plus == cnt_q) begin
						idx_d = idx_q - IDX_BITS'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			live_q <= 1'b0;
		end else if (en) begin
			cnt_q  <= cnt_d;
			idx_q  <= idx_d;
			live_q <= live_d;
		end
	end

	assign look_idx = idx_d;
	assign cur_vld  = live_d && (CNT_BITS'(idx_d) < cnt_d);

	assign res.ok           = ok;
	assign res.taken_value  = take_use ? FIELD_BITS'(take_data) : '0;
	assign res.count        = COUNT_BITS'(cnt_d);
	assign res.cursor_valid = cur_vld;
	assign res.cursor_value = cur_vld ? FIELD_BITS'(look_data) : '0;

endmodule

// ===== design/fifo_with_cursor_removal.sv =====
// Top level of the bounded FIFO with cursor and removal at the cursor.
// Depends on cfq_pkg, cfq_store, cfq_ctrl and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_ready  kind, value
//   out      source     out_valid/out_ready  ok, taken_value, count, cursor_valid, cursor_value
//
// From acceptance, each transaction passes through the input register, then
// through the count/cursor logic and the shift array into the result
// register. One transaction is taken every cycle unless the result stalls;
// count, cursor and entries are all updated at once, which allows that rate.
// Reset clears the count and the cursor; the entries are left as they are.
// A stalled result holds the operation in the input register, and in_ready
// drops only while both registers are full and out_ready is low.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fifo_with_cursor_removal
	import cfq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               kind,
	input  logic signed [31:0]       value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     ok,
	output logic signed [31:0]       taken_value,
	output logic [COUNT_BITS-1:0]    count,
	output logic                     cursor_valid,
	output logic signed [31:0]       cursor_value
);

	// Input register stage.
	logic                 valid_s1;
	logic [2:0]           kind_s1;
	logic [DATA_BITS-1:0] value_s1;

	// Result register stage.
	logic                 valid_s2;
	result_t              res_s2;

	logic                 advance;
	logic                 in_take;
	store_cmd_t           cmd;
	logic [IDX_BITS-1:0]  take_idx;
	logic [DATA_BITS-1:0] take_data;
	logic [IDX_BITS-1:0]  look_idx;
	logic [DATA_BITS-1:0] look_data;
	result_t              res;

	// Advance the held operation whenever the result register is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload until the operation moves on.
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1  <= kind;
			value_s1 <= DATA_BITS'($unsigned(value));
		end
	end

	cfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.kind      (kind_s1),
		.wdata     (value_s1),
		.cmd       (cmd),
		.take_idx  (take_idx),
		.take_data (take_data),
		.look_idx  (look_idx),
		.look_data (look_data),
		.res       (res)
	);

	cfq_store u_store (
		.clk       (clk),
		.cmd       (cmd),
		.take_idx  (take_idx),
		.take_data (take_data),
		.look_idx  (look_idx),
		.look_data (look_data)
	);

	// Drop the result once taken unless a new one replaces it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign ok           = res_s2.ok;
	assign taken_value  = $signed(res_s2.taken_value);
	assign count        = res_s2.count;
	assign cursor_valid = res_s2.cursor_valid;
	assign cursor_value = $signed(res_s2.cursor_value);

	`CFQ_ASSERT_IMPLY(a_count_bound, clk, arst_n, out_valid, count <= COUNT_BITS'(DEPTH), "count above depth")
	`CFQ_ASSERT_IMPLY(a_cursor_needs_entry, clk, arst_n, out_valid && cursor_valid, count != '0, "cursor valid on empty queue")
	`CFQ_ASSERT_IMPLY(a_fail_takes_nothing, clk, arst_n, out_valid && !ok, taken_value == '0, "failed operation took a word")
	`CFQ_ASSERT_IMPLY(a_stall_blocks_input, clk, arst_n, valid_s1 && valid_s2 && !out_ready, !in_ready, "input taken while both stages stalled")

endmodule
